@@ rtl/btq_pkg.sv @@
package btq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TONE_W  = 16;
  localparam int OP_W    = 2;
  localparam int LEVEL_W = 6;

  // levels run from 0 (always high) to 32 (always low)
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 6'd32;
  localparam int                 TONE_ID_LIMIT = 32;

  localparam int DIV_STEPS = TONE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR  = 2'd2;

  typedef enum logic [1:0] {
    K_TICK,
    K_ENQ,
    K_CLR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [LEVEL_W-1:0] level;
    logic [TONE_W-1:0]  ticks;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [TONE_W-1:0]  dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/btq_front.sv @@
module btq_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [btq_pkg::OP_W-1:0]    in_op,
  input  logic [btq_pkg::TONE_W-1:0]  in_tone_id,
  input  logic [btq_pkg::TONE_W-1:0]  in_tone_length,
  output logic                        cmd_valid,
  output btq_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);

  btq_pkg::cmd_t    fifo_r [2];
  logic [1:0]       count_r;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  btq_pkg::cmd_t    cmd_nxt;
  logic             push;
  logic             pop;

  always_comb begin
    cmd_nxt = '0;
    case (in_op)
      btq_pkg::OP_TICK: cmd_nxt.kind = btq_pkg::K_TICK;
      btq_pkg::OP_ENQ:  cmd_nxt.kind = btq_pkg::K_ENQ;
      btq_pkg::OP_CLR:  cmd_nxt.kind = btq_pkg::K_CLR;
      default:          cmd_nxt.kind = btq_pkg::K_NOP;
    endcase
    if (in_tone_id < btq_pkg::TONE_W'(btq_pkg::TONE_ID_LIMIT)) begin
      cmd_nxt.level = btq_pkg::LEVEL_MAX - {1'b0, in_tone_id[4:0]};
    end else begin
      cmd_nxt.level = '0;
    end
    // times five, truncated to the field width
    cmd_nxt.ticks = {in_tone_length[btq_pkg::TONE_W-3:0], 2'b00} + in_tone_length;
  end

  assign in_stall  = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

@@ rtl/btq_div.sv @@
module btq_div (
  input  logic              clk,
  input  logic              rst_n,
  input  btq_pkg::div_req_t req,
  output btq_pkg::div_rsp_t rsp
);

  logic [btq_pkg::TONE_W-1:0]    shift_r;
  logic [btq_pkg::LEVEL_W-1:0]   rem_r;
  logic [btq_pkg::LEVEL_W-1:0]   divisor_r;
  logic [btq_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [btq_pkg::LEVEL_W:0]     trial;
  logic [btq_pkg::LEVEL_W-1:0]   rem_nxt;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem_r, shift_r[btq_pkg::TONE_W-1]};
    if (trial >= {1'b0, divisor_r}) begin
      rem_nxt = btq_pkg::LEVEL_W'(trial - {1'b0, divisor_r});
    end else begin
      rem_nxt = trial[btq_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift_r   <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      shift_r <= {shift_r[btq_pkg::TONE_W-2:0], 1'b0};
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= btq_pkg::DIV_CNT_W'(btq_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == btq_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/btq_back.sv @@
module btq_back #(
  parameter int QUEUE_DEPTH = btq_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  btq_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output btq_pkg::div_req_t div_req,
  input  btq_pkg::div_rsp_t div_rsp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_pin_level,
  output logic              out_accepted,
  output logic [CNT_W-1:0]  out_queued_count,
  output logic              out_active
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WORD_W = btq_pkg::LEVEL_W + btq_pkg::TONE_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            wc_r;
  logic [CNT_W-1:0]            pos_r;
  logic                        playing_r;
  logic                        pin_r;
  logic                        acc_r;
  logic                        out_valid_r;
  logic                        out_pin_r;
  logic                        out_acc_r;
  logic [CNT_W-1:0]            out_count_r;
  logic                        out_active_r;

  logic [WORD_W-1:0]           mem [QUEUE_DEPTH];
  logic [WORD_W-1:0]           rd_data_r;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_addr;
  logic [WORD_W-1:0]           mem_wdata;

  logic [btq_pkg::LEVEL_W-1:0] rd_level;
  logic [btq_pkg::TONE_W-1:0]  rd_ticks;
  logic [CNT_W-1:0]            pos_inc;
  logic                        need_div;

  assign rd_level = rd_data_r[WORD_W-1:btq_pkg::TONE_W];
  assign rd_ticks = rd_data_r[btq_pkg::TONE_W-1:0];
  assign pos_inc  = pos_r + 1'b1;
  assign need_div = (rd_ticks != '0) && (rd_level != '0) && (rd_level != btq_pkg::LEVEL_MAX);

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  assign div_req.start    = (state_r == S_READ) && need_div;
  assign div_req.dividend = rd_ticks;
  assign div_req.divisor  = rd_level;

  // one write port: enqueue stores at the tail, play writes back the count
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pos_r[IDX_W-1:0];
    mem_wdata = {rd_level, rd_ticks - 1'b1};
    if (state_r == S_WB) begin
      mem_we = 1'b1;
    end else if (cmd_pop && (cmd.kind == btq_pkg::K_ENQ) && (wc_r < DEPTH_C)) begin
      mem_we    = 1'b1;
      mem_addr  = wc_r[IDX_W-1:0];
      mem_wdata = {cmd.level, cmd.ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[pos_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      pos_r       <= '0;
      playing_r   <= 1'b0;
      pin_r       <= 1'b0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            acc_r <= 1'b0;
            case (cmd.kind)
              btq_pkg::K_TICK: begin
                state_r <= playing_r ? S_READ : S_DONE;
              end
              btq_pkg::K_ENQ: begin
                if (wc_r < DEPTH_C) begin
                  if ((wc_r == '0) && !playing_r) begin
                    pos_r <= '0;
                  end
                  playing_r <= 1'b1;
                  wc_r      <= wc_r + 1'b1;
                  acc_r     <= 1'b1;
                end
                state_r <= S_DONE;
              end
              btq_pkg::K_CLR: begin
                wc_r      <= '0;
                playing_r <= 1'b0;
                pin_r     <= 1'b0;
                state_r   <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          if (rd_ticks != '0) begin
            if (rd_level == '0) begin
              pin_r   <= 1'b1;
              state_r <= S_WB;
            end else if (rd_level == btq_pkg::LEVEL_MAX) begin
              pin_r   <= 1'b0;
              state_r <= S_WB;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            // entry expired: advance, empty the queue after the last one
            pin_r <= 1'b0;
            if ((pos_inc == wc_r) || (pos_inc >= DEPTH_C)) begin
              wc_r      <= '0;
              playing_r <= 1'b0;
              pos_r     <= '0;
            end else begin
              pos_r <= pos_inc;
            end
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            pin_r   <= (div_rsp.rem == '0);
            state_r <= S_WB;
          end
        end
        S_WB: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_pin_r    <= pin_r;
            out_acc_r    <= acc_r;
            out_count_r  <= wc_r;
            out_active_r <= playing_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin_level    = out_pin_r;
  assign out_accepted     = out_acc_r;
  assign out_queued_count = out_count_r;
  assign out_active       = out_active_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= DEPTH_C)
    else $error("write count above queue depth");

  a_play_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (pos_r < wc_r))
    else $error("play position outside written entries");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !playing_r |-> (wc_r == '0))
    else $error("entries counted while queue inactive");

  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on modulo unit that is not running");
`endif

endmodule

@@ rtl/beeper_tone_queue.sv @@
// a tick that needs the modulo passes from transfer in through the store read, the 16-step
// serial modulo and the write back to result transfer; a tick on a level of 0 or 32 skips the modulo
// the back end handles one command at a time, and enqueue, clear and idle ticks skip the modulo;
// a 2-entry command queue takes items meanwhile
// reset is synchronous and clears the counters, flags, pin and handshakes; the tone
// stores are not cleared and hold nothing meaningful until written
module beeper_tone_queue #(
  parameter int QUEUE_DEPTH = btq_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [btq_pkg::OP_W-1:0]    in_op,
  input  logic [btq_pkg::TONE_W-1:0]  in_tone_id,
  input  logic [btq_pkg::TONE_W-1:0]  in_tone_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pin_level,
  output logic                        out_accepted,
  output logic [CNT_W-1:0]            out_queued_count,
  output logic                        out_active
);

  logic              cmd_valid;
  btq_pkg::cmd_t     cmd;
  logic              cmd_pop;
  btq_pkg::div_req_t div_req;
  btq_pkg::div_rsp_t div_rsp;

  btq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_tone_id     (in_tone_id),
    .in_tone_length (in_tone_length),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  btq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  btq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pin_level    (out_pin_level),
    .out_accepted     (out_accepted),
    .out_queued_count (out_queued_count),
    .out_active       (out_active)
  );

endmodule

@@ verif/tb_beeper_tone_queue.sv @@
module tb_beeper_tone_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = btq_pkg::QUEUE_DEPTH_DEF;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [btq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic             pin_level;
    logic             accepted;
    logic [CNT_W-1:0] queued_count;
    logic             active;
  } tone_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [btq_pkg::OP_W-1:0]    in_op;
  logic [btq_pkg::TONE_W-1:0]  in_tone_id;
  logic [btq_pkg::TONE_W-1:0]  in_tone_length;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_pin_level;
  logic                        out_accepted;
  logic [CNT_W-1:0]            out_queued_count;
  logic                        out_active;

  // shadow of the tone queue
  logic [btq_pkg::LEVEL_W-1:0] q_level [QUEUE_DEPTH];
  logic [btq_pkg::TONE_W-1:0]  q_ticks [QUEUE_DEPTH];
  int                          q_fill;
  bit                          q_playing;
  int                          q_head;
  bit                          q_pin;

  tone_result_t        due_results[$];
  int                  fail_count;
  int                  items_sent;
  bit                  tx_idle;
  bit                  rx_idle;
  int                  rx_hold_cycles;

  beeper_tone_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_tone_id       (in_tone_id),
    .in_tone_length   (in_tone_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pin_level    (out_pin_level),
    .out_accepted     (out_accepted),
    .out_queued_count (out_queued_count),
    .out_active       (out_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void empty_tone_queue();
    q_fill    = 0;
    q_playing = 1'b0;
    q_head    = 0;
  endfunction

  function automatic tone_result_t next_buzzer_state(logic [btq_pkg::OP_W-1:0] op,
                                                     logic [btq_pkg::TONE_W-1:0] tone_id,
                                                     logic [btq_pkg::TONE_W-1:0] tone_len);
    tone_result_t                res;
    logic [btq_pkg::TONE_W-1:0]  left;
    int unsigned                 lvl;
    res.accepted = 1'b0;
    case (op)
      btq_pkg::OP_TICK: begin
        if (q_playing) begin
          if (q_head >= QUEUE_DEPTH) begin
            empty_tone_queue();
          end else if (q_ticks[q_head] != '0) begin
            left = q_ticks[q_head];
            lvl  = q_level[q_head];
            if (lvl == 0) q_pin = 1'b1;
            else if (lvl == btq_pkg::LEVEL_MAX) q_pin = 1'b0;
            else q_pin = ((left % lvl) == 0);
            q_ticks[q_head] = left - 1'b1;
          end else begin
            // expired entry: pin low, move on, empty when exhausted
            q_pin  = 1'b0;
            q_head = q_head + 1;
            if (q_head == q_fill || q_head >= QUEUE_DEPTH) empty_tone_queue();
          end
        end
      end
      btq_pkg::OP_ENQ: begin
        if (q_fill < QUEUE_DEPTH) begin
          if (q_fill == 0 && !q_playing) q_head = 0;
          q_playing        = 1'b1;
          q_level[q_fill]  = (tone_id < btq_pkg::TONE_ID_LIMIT) ?
                             btq_pkg::LEVEL_W'(btq_pkg::TONE_ID_LIMIT - tone_id) : '0;
          q_ticks[q_fill]  = btq_pkg::TONE_W'(tone_len * 5);
          q_fill           = q_fill + 1;
          res.accepted     = 1'b1;
        end
      end
      btq_pkg::OP_CLR: begin
        // head position is kept; the next enqueue resets it
        q_fill    = 0;
        q_playing = 1'b0;
        q_pin     = 1'b0;
      end
      default: ;
    endcase
    res.pin_level    = q_pin;
    res.queued_count = CNT_W'(q_fill);
    res.active       = q_playing;
    return res;
  endfunction

  task automatic send_item(logic [btq_pkg::OP_W-1:0] op, logic [btq_pkg::TONE_W-1:0] tone_id,
                           logic [btq_pkg::TONE_W-1:0] tone_len);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_op          = op;
    in_tone_id     = tone_id;
    in_tone_length = tone_len;
    do @(posedge clk); while (in_stall);
    due_results.push_back(next_buzzer_state(op, tone_id, tone_len));
    if (op != OP_UNUSED) items_sent++;
  endtask

  function automatic logic [btq_pkg::TONE_W-1:0] pick_tone_id();
    case ($urandom_range(0, 9))
      0:       return btq_pkg::TONE_W'($urandom);
      1:       return btq_pkg::TONE_W'($urandom_range(32, 40));
      default: return btq_pkg::TONE_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [btq_pkg::TONE_W-1:0] pick_tone_length();
    case ($urandom_range(0, 19))
      0:       return btq_pkg::TONE_W'($urandom);
      1, 2:    return btq_pkg::TONE_W'($urandom_range(4, 12));
      default: return btq_pkg::TONE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // result side: per-result stall draw, plus an optional long hold
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, 12) : 0;
      if (rx_hold_cycles > 0) begin
        wait_cycles    = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk);
      out_stall = (wait_cycles > 0);
      repeat (wait_cycles) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    tone_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_pin_level !== want.pin_level) begin
          $error("pin_level: expected %0d, got %0d", want.pin_level, out_pin_level);
          fail_count++;
        end
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_accepted);
          fail_count++;
        end
        if (out_queued_count !== want.queued_count) begin
          $error("queued_count: expected %0d, got %0d", want.queued_count, out_queued_count);
          fail_count++;
        end
        if (out_active !== want.active) begin
          $error("active: expected %0d, got %0d", want.active, out_active);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed_tones();
    // idle queue: tick, clear and the unused op change nothing
    send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(btq_pkg::OP_CLR, 16'hffff, 16'hffff);
    send_item(OP_UNUSED, 16'h0000, 16'h0000);
    // always-low level, five ticks then expiry
    send_item(btq_pkg::OP_ENQ, 16'd0, 16'd1);
    repeat (6) send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    // level 1, loudest from id 32 and from the top id, zero lengths
    send_item(btq_pkg::OP_ENQ, 16'd31, 16'd1);
    send_item(btq_pkg::OP_ENQ, 16'd32, 16'd0);
    send_item(btq_pkg::OP_ENQ, 16'hffff, 16'd0);
    repeat (8) send_item(btq_pkg::OP_TICK, 16'hffff, 16'hffff);
    // mid level pulsing, cut short by a clear
    send_item(btq_pkg::OP_ENQ, 16'd27, 16'd3);
    repeat (3) send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(btq_pkg::OP_CLR, 16'h0000, 16'h0000);
    send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    // longest length wraps at 16 bits
    send_item(btq_pkg::OP_ENQ, 16'd1, 16'hffff);
    send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_UNUSED, 16'hffff, 16'hffff);
    send_item(btq_pkg::OP_CLR, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(btq_pkg::OP_ENQ, 16'(i * 2), 16'd0);
    send_item(btq_pkg::OP_ENQ, 16'd5, 16'd2);  // refused
    repeat (QUEUE_DEPTH) send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    // clear with the head moved on, then refill from slot zero
    repeat (3) send_item(btq_pkg::OP_ENQ, 16'd40, 16'd0);
    send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(btq_pkg::OP_CLR, 16'h0000, 16'h0000);
    send_item(btq_pkg::OP_ENQ, 16'd20, 16'd1);
    repeat (6) send_item(btq_pkg::OP_TICK, 16'h0000, 16'h0000);
  endtask

  task automatic test_backpressure();
    tx_idle        = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) begin
        send_item(btq_pkg::OP_ENQ, pick_tone_id(), btq_pkg::TONE_W'($urandom_range(0, 3)));
      end else begin
        send_item(btq_pkg::OP_TICK, btq_pkg::TONE_W'($urandom), btq_pkg::TONE_W'($urandom));
      end
    end
    send_item(btq_pkg::OP_CLR, 16'h0000, 16'h0000);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_sequences();
    int n_tones;
    int n_ticks;
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // noise: anything the fields allow
        repeat ($urandom_range(1, 8))
          send_item(btq_pkg::OP_W'($urandom_range(0, 3)), btq_pkg::TONE_W'($urandom),
                    btq_pkg::TONE_W'($urandom));
      end else begin
        if (q_fill >= 12 || $urandom_range(0, 1) == 0)
          send_item(btq_pkg::OP_CLR, btq_pkg::TONE_W'($urandom), btq_pkg::TONE_W'($urandom));
        n_tones = $urandom_range(1, 6);
        repeat (n_tones) send_item(btq_pkg::OP_ENQ, pick_tone_id(), pick_tone_length());
        n_ticks = 0;
        while (q_playing && n_ticks < 80) begin
          case ($urandom_range(0, 29))
            0: send_item(btq_pkg::OP_CLR, btq_pkg::TONE_W'($urandom),
                         btq_pkg::TONE_W'($urandom));
            1, 2, 3: send_item(btq_pkg::OP_ENQ, pick_tone_id(), pick_tone_length());
            default: send_item(btq_pkg::OP_TICK, btq_pkg::TONE_W'($urandom),
                               btq_pkg::TONE_W'($urandom));
          endcase
          n_ticks++;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = btq_pkg::OP_TICK;
    in_tone_id     = '0;
    in_tone_length = '0;
    fail_count     = 0;
    items_sent     = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold_cycles = 0;
    q_fill         = 0;
    q_playing      = 1'b0;
    q_head         = 0;
    q_pin          = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed_tones();
    test_full_queue();
    test_backpressure();
    test_random_sequences();

    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/btq_pkg.sv
rtl/btq_front.sv
rtl/btq_div.sv
rtl/btq_back.sv
rtl/beeper_tone_queue.sv
verif/tb_beeper_tone_queue.sv
